>>> design/pbrt_pkg.sv
package pbrt_pkg;

  localparam int PRIORITY_LEVELS_DEF = 256;
  localparam int MAX_TASKS_DEF       = 255;

  localparam int PRI_W       = 8;
  localparam int LEVEL_BITS  = 32;
  localparam int LEVEL_SHIFT = 5;

  localparam logic OP_PUT    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic find_group;
    logic load_result;
  } cmd_t;

  // Index of the lowest set bit of a level word, 0 for an empty word.
  function automatic logic [LEVEL_SHIFT-1:0] lowest_set(input logic [LEVEL_BITS-1:0] w);
    logic [LEVEL_SHIFT-1:0] idx;
    idx = '0;
    for (int i = LEVEL_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = LEVEL_SHIFT'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/pbrt_ctrl.sv
module pbrt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output pbrt_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_GROUP,
    S_LEVEL
  } state_t;

  state_t state;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign cmd.capture     = accept;
  assign cmd.read        = (state == S_READ);
  assign cmd.update      = (state == S_UPDATE);
  assign cmd.find_group  = (state == S_GROUP);
  assign cmd.load_result = (state == S_LEVEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_LEVEL);
      unique case (state)
        S_IDLE:   if (accept) state <= S_READ;
        S_READ:   state <= S_UPDATE;
        S_UPDATE: state <= S_GROUP;
        S_GROUP:  state <= S_LEVEL;
        S_LEVEL:  state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted item did not start work");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done) else $error("result not delivered five cycles after accept");

endmodule

>>> design/pbrt_datapath.sv
module pbrt_datapath #(
  parameter int PRIORITY_LEVELS     = pbrt_pkg::PRIORITY_LEVELS_DEF,
  parameter int MAX_TASKS_PER_LEVEL = pbrt_pkg::MAX_TASKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pbrt_pkg::cmd_t             cmd,
  input  logic                       opcode,
  input  logic [pbrt_pkg::PRI_W-1:0] priority_req,
  output logic [pbrt_pkg::PRI_W-1:0] highest_priority,
  output logic                       any_ready,
  output logic                       op_error
);

  localparam int GROUP_COUNT = (PRIORITY_LEVELS + pbrt_pkg::LEVEL_BITS - 1) /
                               pbrt_pkg::LEVEL_BITS;
  localparam int GRP_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int ADDR_W = $clog2(PRIORITY_LEVELS);
  localparam int CNT_W  = $clog2(MAX_TASKS_PER_LEVEL + 1);

  logic                       opcode_r;
  logic [pbrt_pkg::PRI_W-1:0] pri_r;

  logic [CNT_W-1:0]           count_mem [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] count_valid;
  logic [CNT_W-1:0]           rd_count;
  logic                       rd_valid;

  logic [pbrt_pkg::LEVEL_BITS-1:0] level_map [GROUP_COUNT];
  logic [GROUP_COUNT-1:0]          group_map;
  logic                            err_r;

  logic [GRP_W-1:0] grp_sel;
  logic             grp_any;

  logic [ADDR_W-1:0]                addr;
  logic [GRP_W-1:0]                 grp;
  logic [pbrt_pkg::LEVEL_SHIFT-1:0] bit_idx;
  logic                             in_range;
  logic [CNT_W-1:0]                 cur_count;
  logic [CNT_W-1:0]                 new_count;
  logic                             upd_err;
  logic [pbrt_pkg::LEVEL_BITS-1:0]  new_word;
  logic [GRP_W-1:0]                 grp_first;
  logic [GRP_W+pbrt_pkg::LEVEL_SHIFT-1:0] hi_full;

  assign addr     = ADDR_W'(pri_r);
  assign grp      = GRP_W'(pri_r >> pbrt_pkg::LEVEL_SHIFT);
  assign bit_idx  = pri_r[pbrt_pkg::LEVEL_SHIFT-1:0];
  assign in_range = (32'(pri_r) < 32'(PRIORITY_LEVELS));
  assign cur_count = rd_valid ? rd_count : '0;

  always_comb begin
    new_count = cur_count;
    upd_err   = 1'b0;
    new_word  = level_map[grp];
    if (!in_range) begin
      upd_err = 1'b1;
    end else if (opcode_r == pbrt_pkg::OP_PUT) begin
      upd_err   = (cur_count >= CNT_W'(MAX_TASKS_PER_LEVEL));
      new_count = cur_count + 1'b1;
      new_word[bit_idx] = 1'b1;
    end else begin
      upd_err   = (cur_count == '0);
      new_count = cur_count - 1'b1;
      if (new_count == '0) begin
        new_word[bit_idx] = 1'b0;
      end
    end
  end

  // The highest-numbered set bit is overwritten by lower ones, leaving the lowest.
  always_comb begin
    grp_first = '0;
    for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
      if (group_map[i]) begin
        grp_first = GRP_W'(i);
      end
    end
  end

  assign hi_full = {grp_sel, pbrt_pkg::lowest_set(level_map[grp_sel])};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r <= opcode;
      pri_r    <= priority_req;
    end
    if (cmd.read) begin
      rd_count <= count_mem[addr];
    end
    if (cmd.update && !upd_err) begin
      count_mem[addr] <= new_count;
    end
    if (cmd.find_group) begin
      grp_sel <= grp_first;
      grp_any <= |group_map;
    end
    if (cmd.load_result) begin
      any_ready        <= grp_any;
      highest_priority <= grp_any ? pbrt_pkg::PRI_W'(hi_full) : '0;
      op_error         <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= '0;
      rd_valid    <= 1'b0;
      group_map   <= '0;
      err_r       <= 1'b0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
        level_map[g] <= '0;
      end
    end else begin
      if (cmd.read) begin
        rd_valid <= count_valid[addr];
      end
      if (cmd.update) begin
        err_r <= upd_err;
        if (!upd_err) begin
          count_valid[addr] <= 1'b1;
          level_map[grp]    <= new_word;
          group_map[grp]    <= |new_word;
        end
      end
    end
  end

endmodule

>>> design/priority_bitmap_ready_tracker.sv
// After the accepting edge the controller steps through S_READ, S_UPDATE, S_GROUP and
// S_LEVEL: the count memory read, its update, the group search and the level search each
// take one controller state. done rises and results are registered as S_LEVEL ends; busy is
// high until then, so a new item is taken only after the last one is through.
// Reset (rst, synchronous) empties every level: counts, level words and group bits clear.
// Results cannot be held off; each one is present for the single cycle that done is high.
module priority_bitmap_ready_tracker #(
  parameter int PRIORITY_LEVELS     = pbrt_pkg::PRIORITY_LEVELS_DEF,
  parameter int MAX_TASKS_PER_LEVEL = pbrt_pkg::MAX_TASKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode,
  input  logic [pbrt_pkg::PRI_W-1:0] priority_req,
  output logic                       done,
  output logic [pbrt_pkg::PRI_W-1:0] highest_priority,
  output logic                       any_ready,
  output logic                       op_error
);

  pbrt_pkg::cmd_t cmd;

  pbrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  pbrt_datapath #(
    .PRIORITY_LEVELS     (PRIORITY_LEVELS),
    .MAX_TASKS_PER_LEVEL (MAX_TASKS_PER_LEVEL)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .opcode           (opcode),
    .priority_req     (priority_req),
    .highest_priority (highest_priority),
    .any_ready        (any_ready),
    .op_error         (op_error)
  );

endmodule

>>> tb/sv/tb_priority_bitmap_ready_tracker.sv
`timescale 1ns / 100ps

module tb_priority_bitmap_ready_tracker;

  localparam int LEVELS    = pbrt_pkg::PRIORITY_LEVELS_DEF;
  localparam int MAX_TASKS = pbrt_pkg::MAX_TASKS_DEF;
  localparam int GROUPS    = (LEVELS + pbrt_pkg::LEVEL_BITS - 1) / pbrt_pkg::LEVEL_BITS;
  localparam int ITEMS     = 1313;

  typedef struct packed {
    logic [pbrt_pkg::PRI_W-1:0] top_level;
    logic                       ready;
    logic                       rejected;
  } ready_status_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       opcode = pbrt_pkg::OP_PUT;
  logic [pbrt_pkg::PRI_W-1:0] priority_req = '0;
  logic                       busy;
  logic                       done;
  logic [pbrt_pkg::PRI_W-1:0] highest_priority;
  logic                       any_ready;
  logic                       op_error;

  // Shadow of the tracker contents.
  int unsigned     task_count [LEVELS];
  logic [31:0]     level_word [GROUPS];
  logic [GROUPS-1:0] group_bits;

  ready_status_t   expected_status [$];
  int              error_count = 0;
  bit              no_gaps = 1'b0;
  logic [pbrt_pkg::PRI_W-1:0] hot_levels [6];

  priority_bitmap_ready_tracker uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .priority_req     (priority_req),
    .done             (done),
    .highest_priority (highest_priority),
    .any_ready        (any_ready),
    .op_error         (op_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("tb_priority_bitmap_ready_tracker: errors");
    $finish;
  end

  function automatic void clear_tracker();
    for (int i = 0; i < LEVELS; i++) task_count[i] = 0;
    for (int g = 0; g < GROUPS; g++) level_word[g] = '0;
    group_bits = '0;
  endfunction

  // Applies one item to the shadow state and returns the status it should produce.
  function automatic ready_status_t track_item(input logic op,
                                               input logic [pbrt_pkg::PRI_W-1:0] pri);
    ready_status_t st;
    int grp;
    int g_first;
    int b_first;
    grp = int'(pri) >> pbrt_pkg::LEVEL_SHIFT;
    st = '0;
    if (int'(pri) >= LEVELS) begin
      st.rejected = 1'b1;
    end else if (op == pbrt_pkg::OP_PUT) begin
      if (task_count[pri] >= MAX_TASKS) begin
        st.rejected = 1'b1;
      end else begin
        task_count[pri]++;
        level_word[grp][pri[pbrt_pkg::LEVEL_SHIFT-1:0]] = 1'b1;
        group_bits[grp] = 1'b1;
      end
    end else begin
      if (task_count[pri] == 0) begin
        st.rejected = 1'b1;
      end else begin
        task_count[pri]--;
        if (task_count[pri] == 0) begin
          level_word[grp][pri[pbrt_pkg::LEVEL_SHIFT-1:0]] = 1'b0;
          if (level_word[grp] == '0) group_bits[grp] = 1'b0;
        end
      end
    end
    st.ready = (group_bits != '0);
    if (st.ready) begin
      g_first = -1;
      for (int g = GROUPS - 1; g >= 0; g--) if (group_bits[g]) g_first = g;
      b_first = 0;
      for (int b = pbrt_pkg::LEVEL_BITS - 1; b >= 0; b--)
        if (level_word[g_first][b]) b_first = b;
      st.top_level = pbrt_pkg::PRI_W'(g_first * pbrt_pkg::LEVEL_BITS + b_first);
    end
    return st;
  endfunction

  // Any level that currently holds a task, searched from a random point; that point if none does.
  function automatic logic [pbrt_pkg::PRI_W-1:0] pick_ready_level();
    logic [pbrt_pkg::PRI_W-1:0] idx;
    idx = pbrt_pkg::PRI_W'($urandom_range(0, LEVELS - 1));
    for (int i = 0; i < LEVELS; i++) begin
      if (task_count[idx] != 0) return idx;
      idx = idx + 1'b1;
    end
    return idx;
  endfunction

  function automatic logic [pbrt_pkg::PRI_W-1:0] track_top();
    for (int i = 0; i < LEVELS; i++)
      if (task_count[i] != 0) return pbrt_pkg::PRI_W'(i);
    return '0;
  endfunction

  task automatic send_item(input logic op, input logic [pbrt_pkg::PRI_W-1:0] pri);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    priority_req <= pri;
    do @(posedge clk); while (busy);
    expected_status.push_back(track_item(op, pri));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  always @(posedge clk) begin
    ready_status_t exp_st;
    if (!rst && done) begin
      if (expected_status.size() == 0) begin
        report_mismatch("outstanding item", 0, 1);
      end else begin
        exp_st = expected_status.pop_front();
        if (highest_priority !== exp_st.top_level)
          report_mismatch("highest_priority", 32'(exp_st.top_level), 32'(highest_priority));
        if (any_ready !== exp_st.ready)
          report_mismatch("any_ready", 32'(exp_st.ready), 32'(any_ready));
        if (op_error !== exp_st.rejected)
          report_mismatch("op_error", 32'(exp_st.rejected), 32'(op_error));
      end
    end
  end

  // Extreme levels, group boundaries, removes from empty levels and a full drain.
  task automatic test_directed();
    send_item(pbrt_pkg::OP_REMOVE, 8'd0);
    send_item(pbrt_pkg::OP_PUT,    8'd255);
    send_item(pbrt_pkg::OP_PUT,    8'd0);
    send_item(pbrt_pkg::OP_REMOVE, 8'd0);
    send_item(pbrt_pkg::OP_REMOVE, 8'd0);
    send_item(pbrt_pkg::OP_PUT,    8'd31);
    send_item(pbrt_pkg::OP_PUT,    8'd32);
    send_item(pbrt_pkg::OP_REMOVE, 8'd255);
    send_item(pbrt_pkg::OP_REMOVE, 8'd31);
    send_item(pbrt_pkg::OP_PUT,    8'd128);
    send_item(pbrt_pkg::OP_PUT,    8'd170);
    send_item(pbrt_pkg::OP_PUT,    8'd85);
    send_item(pbrt_pkg::OP_REMOVE, 8'd32);
    send_item(pbrt_pkg::OP_REMOVE, 8'd85);
    send_item(pbrt_pkg::OP_REMOVE, 8'd128);
    send_item(pbrt_pkg::OP_REMOVE, 8'd170);
    send_item(pbrt_pkg::OP_REMOVE, 8'd7);
    send_item(pbrt_pkg::OP_PUT,    8'd63);
    send_item(pbrt_pkg::OP_PUT,    8'd63);
    send_item(pbrt_pkg::OP_REMOVE, 8'd63);
    send_item(pbrt_pkg::OP_REMOVE, 8'd63);
    send_item(pbrt_pkg::OP_REMOVE, 8'd63);
    wait_idle();
  endtask

  // Fill one level to its limit, push past it, then drain and remove once more.
  task automatic test_saturation();
    logic [pbrt_pkg::PRI_W-1:0] lvl;
    lvl = pbrt_pkg::PRI_W'($urandom_range(0, LEVELS - 1));
    no_gaps = 1'b1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (i % 64 == 0) no_gaps = ~no_gaps;
      send_item(pbrt_pkg::OP_PUT, lvl);
    end
    send_item(pbrt_pkg::OP_PUT, lvl);
    send_item(pbrt_pkg::OP_PUT, lvl ^ 8'h80);
    send_item(pbrt_pkg::OP_PUT, lvl);
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (i % 64 == 0) no_gaps = ~no_gaps;
      send_item(pbrt_pkg::OP_REMOVE, lvl);
    end
    send_item(pbrt_pkg::OP_REMOVE, lvl);
    send_item(pbrt_pkg::OP_REMOVE, lvl ^ 8'h80);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // Removes mostly of tasks that exist, puts around a few busy levels, some noise.
  task automatic test_random();
    logic                       op;
    logic [pbrt_pkg::PRI_W-1:0] pri;
    int                         sel;
    hot_levels[0] = 8'd31;
    hot_levels[1] = 8'd32;
    for (int k = 2; k < 6; k++)
      hot_levels[k] = pbrt_pkg::PRI_W'($urandom_range(0, LEVELS - 1));
    for (int n = 0; n < ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) no_gaps = ~no_gaps;
      op  = ($urandom_range(0, 99) < 55) ? pbrt_pkg::OP_PUT : pbrt_pkg::OP_REMOVE;
      sel = $urandom_range(0, 99);
      if (op == pbrt_pkg::OP_REMOVE && sel < 85)
        pri = pick_ready_level();
      else if (sel < 45)
        pri = hot_levels[$urandom_range(0, 5)];
      else if (sel < 65)
        pri = pbrt_pkg::PRI_W'(int'(track_top()) + $urandom_range(0, 3));
      else
        pri = pbrt_pkg::PRI_W'($urandom_range(0, LEVELS - 1));
      send_item(op, pri);
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  initial begin
    clear_tracker();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_status.size() == 0) begin
      $display("tb_priority_bitmap_ready_tracker: clean");
    end else begin
      $display("tb_priority_bitmap_ready_tracker: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pbrt_pkg.sv
design/pbrt_ctrl.sv
design/pbrt_datapath.sv
design/priority_bitmap_ready_tracker.sv
tb/sv/tb_priority_bitmap_ready_tracker.sv
